FILE: rtl/core/lmdc_pkg.sv
// ----------------------------------------------------------------------------
// lmdc_pkg
// Shared types, widths and the sine table for the LFO modulated delay chorus.
// ----------------------------------------------------------------------------
package lmdc_pkg;

    // Item and register widths
    localparam int SAMPLE_BITS = 24;
    localparam int OUT_BITS    = 25;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 32;
    localparam int RATE_W      = 10;
    localparam int DELAY_W     = 12;
    localparam int LEN_W       = 13;
    localparam int GAIN_W      = 9;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 13;
    localparam int PHASE_W     = 16;

    // Shared multiplier: signed sample-wide operand times a 22-bit operand
    localparam int MUL_B_W     = 22;
    localparam int PROD_W      = SAMPLE_BITS + MUL_B_W;

    // Phase step: rate * 2^STEP_FRAC / (fs * 10), via reciprocal scaled by 2^RECIP_SHIFT
    localparam int STEP_FRAC   = 16;
    localparam int RECIP_SHIFT = 32;
    localparam int Q_LSB       = RECIP_SHIFT - STEP_FRAC;
    localparam int Q_W         = 11;
    localparam int NUM_W       = RATE_W + STEP_FRAC + 1;

    // Fixed shifts and gain limit
    localparam int MOD_SHIFT   = 7;
    localparam int MIX_SHIFT   = 8;
    localparam logic [GAIN_W-1:0] GAIN_UNITY = 9'd256;

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RATE   = 3'd0,
        CFG_BASE   = 3'd1,
        CFG_DEPTH  = 3'd2,
        CFG_LENGTH = 3'd3,
        CFG_DRY    = 3'd4,
        CFG_WET    = 3'd5
    } cfg_index_t;

    // Quarter wave: round(127*sin(k*pi/128)), k = 0..64
    function automatic logic [6:0] quarter_wave(input logic [6:0] k);
        logic [6:0] q;
        case (k)
            7'd0:  q = 7'd0;   7'd1:  q = 7'd3;   7'd2:  q = 7'd6;   7'd3:  q = 7'd9;
            7'd4:  q = 7'd12;  7'd5:  q = 7'd16;  7'd6:  q = 7'd19;  7'd7:  q = 7'd22;
            7'd8:  q = 7'd25;  7'd9:  q = 7'd28;  7'd10: q = 7'd31;  7'd11: q = 7'd34;
            7'd12: q = 7'd37;  7'd13: q = 7'd40;  7'd14: q = 7'd43;  7'd15: q = 7'd46;
            7'd16: q = 7'd49;  7'd17: q = 7'd51;  7'd18: q = 7'd54;  7'd19: q = 7'd57;
            7'd20: q = 7'd60;  7'd21: q = 7'd63;  7'd22: q = 7'd65;  7'd23: q = 7'd68;
            7'd24: q = 7'd71;  7'd25: q = 7'd73;  7'd26: q = 7'd76;  7'd27: q = 7'd78;
            7'd28: q = 7'd81;  7'd29: q = 7'd83;  7'd30: q = 7'd85;  7'd31: q = 7'd88;
            7'd32: q = 7'd90;  7'd33: q = 7'd92;  7'd34: q = 7'd94;  7'd35: q = 7'd96;
            7'd36: q = 7'd98;  7'd37: q = 7'd100; 7'd38: q = 7'd102; 7'd39: q = 7'd104;
            7'd40: q = 7'd106; 7'd41: q = 7'd107; 7'd42: q = 7'd109; 7'd43: q = 7'd111;
            7'd44: q = 7'd112; 7'd45: q = 7'd113; 7'd46: q = 7'd115; 7'd47: q = 7'd116;
            7'd48: q = 7'd117; 7'd49: q = 7'd118; 7'd50: q = 7'd120; 7'd51: q = 7'd121;
            7'd52: q = 7'd122; 7'd53: q = 7'd122; 7'd54: q = 7'd123; 7'd55: q = 7'd124;
            7'd56: q = 7'd125; 7'd57: q = 7'd125; 7'd58: q = 7'd126; 7'd59: q = 7'd126;
            7'd60: q = 7'd126; 7'd61: q = 7'd127; 7'd62: q = 7'd127; 7'd63: q = 7'd127;
            7'd64: q = 7'd127;
            default: q = 7'd0;
        endcase
        return q;
    endfunction

    // Signed sine offset (-127..127) for an 8-bit phase
    function automatic logic signed [7:0] sine_level(input logic [7:0] idx);
        logic [7:0]        k;
        logic [6:0]        q;
        logic signed [7:0] res;
        if (idx <= 8'd64) begin
            k   = idx;
            q   = quarter_wave(k[6:0]);
            res = $signed({1'b0, q});
        end else if (idx <= 8'd128) begin
            k   = 8'd128 - idx;
            q   = quarter_wave(k[6:0]);
            res = $signed({1'b0, q});
        end else if (idx <= 8'd192) begin
            k   = idx - 8'd128;
            q   = quarter_wave(k[6:0]);
            res = -$signed({1'b0, q});
        end else begin
            k   = 8'd0 - idx;
            q   = quarter_wave(k[6:0]);
            res = -$signed({1'b0, q});
        end
        return res;
    endfunction

endpackage

FILE: rtl/core/lmdc_ram.sv
// ----------------------------------------------------------------------------
// lmdc_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module lmdc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/lfo_modulated_delay_chorus.sv
// ----------------------------------------------------------------------------
// lfo_modulated_delay_chorus
// Chorus effect: sine LFO sweeps the read tap of a circular delay line and
// the delayed sample is mixed with the dry sample.
// ----------------------------------------------------------------------------
// Sequence: after input accept the sequencer steps S_RECIP, S_CORR, S_STEP,
//   S_MOD, S_DELAY, S_INDEX, S_READ, S_WET and S_MIX; S_MODL is inserted before
//   S_READ when the read index needs a full remainder after line_length has
//   shrunk below the write position.
// One item at a time: s_tready stays low until its result is loaded, which
//   may wait on m_tready; the single shared multiplier serves five steps per item.
// Reset: synchronous, active low; then a clearing pass over all LINE_DEPTH
//   addresses zeroes the delay RAM, during which s_tready stays low.
// ----------------------------------------------------------------------------
module lfo_modulated_delay_chorus #(
    parameter int LINE_DEPTH     = 4096,
    parameter int SAMPLE_RATE_HZ = 48000
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Input item
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [lmdc_pkg::S_TDATA_W-1:0]     s_tdata,      // [23:0] sample_in
    // Result item
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [lmdc_pkg::M_TDATA_W-1:0]     m_tdata,      // [24:0] sample_out
    // Configuration writes
    input  logic                               cfg_wr_en,
    input  logic [lmdc_pkg::CFG_IDX_W-1:0]     cfg_wr_index,
    input  logic [lmdc_pkg::CFG_DATA_W-1:0]    cfg_wr_data
);

    import lmdc_pkg::*;

    localparam int AW  = $clog2(LINE_DEPTH);
    localparam int LW  = (LEN_W > $clog2(LINE_DEPTH + 1)) ? LEN_W : $clog2(LINE_DEPTH + 1);
    localparam int VW  = LW + 1;
    localparam int CW  = $clog2(VW);
    localparam int DSW = LW + 2;

    localparam longint unsigned STEP_DIV = longint'(SAMPLE_RATE_HZ) * 10;
    localparam logic [MUL_B_W-1:0] RECIP      = MUL_B_W'((64'd1 << RECIP_SHIFT) / STEP_DIV);
    localparam logic [MUL_B_W-1:0] STEP_DIV_B = MUL_B_W'(STEP_DIV);
    localparam logic [NUM_W-1:0]   STEP_DIV_N = NUM_W'(STEP_DIV);
    localparam logic [LW-1:0]      DEPTH_V    = LW'(LINE_DEPTH);
    localparam logic [AW-1:0]      LAST_ADDR  = AW'(LINE_DEPTH - 1);
    localparam logic [LW-1:0]      MIN_LEN    = LW'(2);
    localparam logic [LW-1:0]      ONE_LW     = LW'(1);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RECIP, S_CORR, S_STEP, S_MOD,
        S_DELAY, S_INDEX, S_MODL, S_READ, S_WET, S_MIX
    } state_t;

    // Registers
    state_t                    state_reg,  state_next;
    logic [AW-1:0]             clr_reg,    clr_next;
    logic [PHASE_W-1:0]        phase_reg,  phase_next;
    logic [AW-1:0]             pos_reg,    pos_next;
    logic signed [SAMPLE_BITS-1:0] x_reg,  x_next;
    logic [Q_W-1:0]            q_reg,      q_next;
    logic signed [PROD_W-1:0]  prod_reg,   prod_next;
    logic [LW-1:0]             delay_reg,  delay_next;
    logic [VW-1:0]             v_reg,      v_next;
    logic [VW-1:0]             rem_reg,    rem_next;
    logic [CW-1:0]             cnt_reg,    cnt_next;
    logic signed [OUT_BITS-1:0] acc_reg,   acc_next;
    logic signed [OUT_BITS-1:0] out_reg,   out_next;
    logic                      m_valid_reg, m_valid_next;
    logic [RATE_W-1:0]         rate_reg,   rate_next;
    logic [DELAY_W-1:0]        base_reg,   base_next;
    logic [DELAY_W-1:0]        depth_reg,  depth_next;
    logic [LEN_W-1:0]          len_reg,    len_next;
    logic [GAIN_W-1:0]         dry_reg,    dry_next;
    logic [GAIN_W-1:0]         wet_reg,    wet_next;

    // Combinational helpers
    logic [LW-1:0]                 len_eff;
    logic [GAIN_W-1:0]             dry_sat;
    logic [GAIN_W-1:0]             wet_sat;
    logic signed [SAMPLE_BITS-1:0] mul_a;
    logic signed [MUL_B_W-1:0]     mul_b;
    logic signed [PROD_W-1:0]      mul_p;
    logic [NUM_W-1:0]              step_rem;
    logic [Q_W-1:0]                step;
    logic signed [DSW-1:0]         dsum;
    logic [VW-1:0]                 v_sum;
    logic [VW-1:0]                 rem_sh;
    logic [VW-1:0]                 pos_inc;
    logic signed [OUT_BITS-1:0]    mix;
    logic                          out_load;
    logic                          ram_we;
    logic [AW-1:0]                 ram_waddr;
    logic [SAMPLE_BITS-1:0]        ram_wdata;
    logic [SAMPLE_BITS-1:0]        ram_rdata;

    // Effective line length, clamped to 2..LINE_DEPTH
    always_comb begin
        len_eff = LW'(len_reg);
        if (len_eff < MIN_LEN) begin
            len_eff = MIN_LEN;
        end else if (len_eff > DEPTH_V) begin
            len_eff = DEPTH_V;
        end
    end

    // Saturate gains at unity
    assign dry_sat = (dry_reg > GAIN_UNITY) ? GAIN_UNITY : dry_reg;
    assign wet_sat = (wet_reg > GAIN_UNITY) ? GAIN_UNITY : wet_reg;

    // Shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_RECIP: begin
                mul_a = $signed(SAMPLE_BITS'(rate_reg));
                mul_b = $signed(RECIP);
            end
            S_CORR: begin
                mul_a = $signed(SAMPLE_BITS'(prod_reg[Q_LSB +: Q_W]));
                mul_b = $signed(STEP_DIV_B);
            end
            S_MOD: begin
                mul_a = SAMPLE_BITS'(sine_level(phase_reg[PHASE_W-1 -: 8]));
                mul_b = $signed(MUL_B_W'(depth_reg));
            end
            S_READ: begin
                mul_a = x_reg;
                mul_b = $signed(MUL_B_W'(dry_sat));
            end
            S_WET: begin
                mul_a = $signed(ram_rdata);
                mul_b = $signed(MUL_B_W'(wet_sat));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // Datapath terms read by the sequencer
    always_comb begin
        step_rem = {1'b0, rate_reg, {STEP_FRAC{1'b0}}} - prod_reg[NUM_W-1:0];
        step     = q_reg + Q_W'(step_rem >= STEP_DIV_N);
        if (step == '0 && rate_reg != '0) begin
            step = Q_W'(1);
        end
        dsum    = $signed(DSW'(base_reg)) + $signed(prod_reg[MOD_SHIFT +: DSW]);
        v_sum   = VW'(pos_reg) + {1'b0, len_eff} - {1'b0, delay_reg};
        rem_sh  = {rem_reg[LW-1:0], v_reg[cnt_reg]};
        pos_inc = VW'(pos_reg) + VW'(1);
        mix     = acc_reg + $signed(prod_reg[MIX_SHIFT +: OUT_BITS]);
    end

    assign out_load = (state_reg == S_MIX) && (!m_valid_reg || m_tready);

    // Sequencer next state
    always_comb begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        x_next       = x_reg;
        q_next       = q_reg;
        prod_next    = prod_reg;
        delay_next   = delay_reg;
        v_next       = v_reg;
        rem_next     = rem_reg;
        cnt_next     = cnt_reg;
        acc_next     = acc_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg;
        rate_next    = rate_reg;
        base_next    = base_reg;
        depth_next   = depth_reg;
        len_next     = len_reg;
        dry_next     = dry_reg;
        wet_next     = wet_reg;

        // Drop the result once taken
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR: begin
                clr_next = clr_reg + AW'(1);
                if (clr_reg == LAST_ADDR) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    x_next     = $signed(s_tdata[SAMPLE_BITS-1:0]);
                    state_next = S_RECIP;
                end
            end
            S_RECIP: begin
                prod_next  = mul_p;
                state_next = S_CORR;
            end
            S_CORR: begin
                q_next     = prod_reg[Q_LSB +: Q_W];
                prod_next  = mul_p;
                state_next = S_STEP;
            end
            S_STEP: begin
                phase_next = phase_reg + PHASE_W'(step);
                state_next = S_MOD;
            end
            S_MOD: begin
                prod_next  = mul_p;
                state_next = S_DELAY;
            end
            S_DELAY: begin
                // Clamp delay to 1..len-1
                if (dsum[DSW-1] || dsum == '0) begin
                    delay_next = ONE_LW;
                end else if (dsum[DSW-2:0] >= {1'b0, len_eff}) begin
                    delay_next = len_eff - ONE_LW;
                end else begin
                    delay_next = dsum[LW-1:0];
                end
                state_next = S_INDEX;
            end
            S_INDEX: begin
                if (v_sum < {len_eff, 1'b0}) begin
                    rem_next   = (v_sum >= {1'b0, len_eff}) ? v_sum - {1'b0, len_eff} : v_sum;
                    state_next = S_READ;
                end else begin
                    v_next     = v_sum;
                    rem_next   = '0;
                    cnt_next   = CW'(VW - 1);
                    state_next = S_MODL;
                end
            end
            S_MODL: begin
                // One remainder bit per cycle
                rem_next = (rem_sh >= {1'b0, len_eff}) ? rem_sh - {1'b0, len_eff} : rem_sh;
                if (cnt_reg == '0) begin
                    state_next = S_READ;
                end else begin
                    cnt_next = cnt_reg - CW'(1);
                end
            end
            S_READ: begin
                prod_next  = mul_p;
                state_next = S_WET;
            end
            S_WET: begin
                acc_next   = $signed(prod_reg[MIX_SHIFT +: OUT_BITS]);
                prod_next  = mul_p;
                state_next = S_MIX;
            end
            S_MIX: begin
                if (out_load) begin
                    out_next     = mix;
                    m_valid_next = 1'b1;
                    pos_next     = (pos_inc >= {1'b0, len_eff}) ? '0 : pos_inc[AW-1:0];
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // Configuration writes
        if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_wr_index))
                CFG_RATE:   rate_next  = cfg_wr_data[RATE_W-1:0];
                CFG_BASE:   base_next  = cfg_wr_data[DELAY_W-1:0];
                CFG_DEPTH:  depth_next = cfg_wr_data[DELAY_W-1:0];
                CFG_LENGTH: len_next   = cfg_wr_data[LEN_W-1:0];
                CFG_DRY:    dry_next   = cfg_wr_data[GAIN_W-1:0];
                CFG_WET:    wet_next   = cfg_wr_data[GAIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            phase_reg   <= '0;
            pos_reg     <= '0;
            m_valid_reg <= 1'b0;
            rate_reg    <= RATE_W'(10);
            base_reg    <= DELAY_W'(960);
            depth_reg   <= DELAY_W'(240);
            len_reg     <= LEN_W'(4096);
            dry_reg     <= GAIN_W'(128);
            wet_reg     <= GAIN_W'(128);
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            m_valid_reg <= m_valid_next;
            rate_reg    <= rate_next;
            base_reg    <= base_next;
            depth_reg   <= depth_next;
            len_reg     <= len_next;
            dry_reg     <= dry_next;
            wet_reg     <= wet_next;
        end
        x_reg     <= x_next;
        q_reg     <= q_next;
        prod_reg  <= prod_next;
        delay_reg <= delay_next;
        v_reg     <= v_next;
        rem_reg   <= rem_next;
        cnt_reg   <= cnt_next;
        acc_reg   <= acc_next;
        out_reg   <= out_next;
    end

    // Delay line RAM: clear sweep after reset, sample write on result load
    assign ram_we    = (state_reg == S_CLEAR) || out_load;
    assign ram_waddr = (state_reg == S_CLEAR) ? clr_reg : pos_reg;
    assign ram_wdata = (state_reg == S_CLEAR) ? '0 : x_reg;

    lmdc_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (LINE_DEPTH)
    ) u_line (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (rem_reg[AW-1:0]),
        .rd_data (ram_rdata)
    );

    // Ports
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'($unsigned(out_reg));

    // Checks
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input item taken while one is in progress");

    a_delay_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_INDEX |-> delay_reg >= ONE_LW && delay_reg < len_eff)
        else $error("clamped delay outside 1..len-1");

    a_read_index: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_READ |-> rem_reg < {1'b0, len_eff})
        else $error("read index not below line length");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg) == S_MIX)
        else $error("result raised outside the mix step");

endmodule
